>>> hw/rtl/setq_pkg.sv
// Shared types and constants for the sorted event time queue.
package setq_pkg;

  localparam int unsigned TimeW       = 32;
  localparam int unsigned QueueDepth  = 16;
  localparam int unsigned CfgIndexW   = 1;

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_CHECK    = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_UNUSED   = 2'd3
  } setq_op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNSET    = 3'd1,
    ST_READ_ERR = 3'd2,
    ST_WINDOW   = 3'd3,
    ST_PAST     = 3'd4,
    ST_FULL     = 3'd5,
    ST_BUSY     = 3'd6
  } setq_status_e;

  typedef enum logic [CfgIndexW-1:0] {
    REG_MIN_VALID_TIME = 1'b0,
    REG_MAX_VALID_TIME = 1'b1
  } setq_reg_e;

  typedef struct packed {
    logic             ins;
    logic             pop;
    logic             clr;
    logic [TimeW-1:0] req_time;
  } setq_ctrl_t;

endpackage

>>> hw/rtl/sorted_event_time_queue_top.sv
// Sorted event time queue: command decode, window checks and the chain of slots.
// Latency: a result is strobed in the cycle after its command is taken.
// Throughput: one command per cycle; every slot compares and shifts in the same cycle.
// busy is always low; results cannot be stalled by the receiver.
// Reset empties the queue and sets the window to its full range; no clearing pass.
module sorted_event_time_queue_top
  import setq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth,
  localparam int unsigned CountW     = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           operation_i,
  input  logic [TimeW-1:0]     request_time_i,
  input  logic [TimeW-1:0]     now_time_i,
  input  logic                 clock_set_i,
  input  logic                 clock_read_ok_i,
  input  logic                 payload_busy_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [TimeW-1:0]     cfg_data_i,
  output logic                 result_valid_o,
  output logic [2:0]           status_o,
  output logic                 fire_event_o,
  output logic [CountW-1:0]    pending_count_o,
  output logic [TimeW-1:0]     next_time_o
);

  logic [TimeW-1:0]  min_q, max_q;
  logic [CountW-1:0] count_q, count_d;
  logic              strobe_q;
  setq_status_e      status_q, status_d;
  logic              fire_q, fire_d;
  setq_ctrl_t        ctrl;
  setq_op_e          op;
  logic              req_in_win, now_in_win, full, head_due, accept;

  logic             valid_w [QUEUE_DEPTH];
  logic             ge_w    [QUEUE_DEPTH];
  logic [TimeW-1:0] time_w  [QUEUE_DEPTH];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign op          = setq_op_e'(operation_i);

  assign req_in_win = (request_time_i >= min_q) && (request_time_i <= max_q);
  assign now_in_win = (now_time_i >= min_q) && (now_time_i <= max_q);
  assign full       = valid_w[QUEUE_DEPTH-1];
  assign head_due   = valid_w[0] && (now_time_i >= time_w[0]);

  always_comb begin
    ctrl          = '0;
    ctrl.req_time = request_time_i;
    status_d      = ST_OK;
    fire_d        = 1'b0;
    count_d       = count_q;
    if (accept) begin
      case (op)
        OP_SCHEDULE: begin
          if (!clock_set_i) begin
            status_d = ST_UNSET;
          end else if (!req_in_win) begin
            status_d = ST_WINDOW;
          end else if (!clock_read_ok_i) begin
            status_d = ST_READ_ERR;
          end else if (request_time_i < now_time_i) begin
            status_d = ST_PAST;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.ins = 1'b1;
            count_d  = count_q + 1'b1;
          end
        end
        OP_CHECK: begin
          if (!clock_set_i) begin
            status_d = ST_UNSET;
          end else if (!clock_read_ok_i) begin
            status_d = ST_READ_ERR;
            ctrl.clr = 1'b1;
            count_d  = '0;
          end else if (!now_in_win) begin
            status_d = ST_WINDOW;
            ctrl.clr = 1'b1;
            count_d  = '0;
          end else if (head_due) begin
            ctrl.pop = 1'b1;
            count_d  = count_q - 1'b1;
            if (payload_busy_i) begin
              status_d = ST_BUSY;
            end else begin
              fire_d = 1'b1;
            end
          end
        end
        OP_CLEAR: begin
          ctrl.clr = 1'b1;
          count_d  = '0;
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic             left_valid, left_ge, right_valid;
    logic [TimeW-1:0] left_time, right_time;

    if (i == 0) begin : g_first
      assign left_valid = 1'b1;
      assign left_ge    = 1'b0;
      assign left_time  = '0;
    end else begin : g_inner_left
      assign left_valid = valid_w[i-1];
      assign left_ge    = ge_w[i-1];
      assign left_time  = time_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_valid = 1'b0;
      assign right_time  = time_w[i];
    end else begin : g_inner_right
      assign right_valid = valid_w[i+1];
      assign right_time  = time_w[i+1];
    end

    setq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .left_valid_i (left_valid),
      .left_ge_i    (left_ge),
      .left_time_i  (left_time),
      .right_valid_i(right_valid),
      .right_time_i (right_time),
      .valid_o      (valid_w[i]),
      .ge_o         (ge_w[i]),
      .time_o       (time_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= '0;
      max_q    <= '1;
      count_q  <= '0;
      strobe_q <= 1'b0;
      status_q <= ST_OK;
      fire_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (setq_reg_e'(cfg_index_i))
          REG_MIN_VALID_TIME: min_q <= cfg_data_i;
          REG_MAX_VALID_TIME: max_q <= cfg_data_i;
          default: ;
        endcase
      end
      count_q  <= count_d;
      strobe_q <= accept;
      if (accept) begin
        status_q <= status_d;
        fire_q   <= fire_d;
      end
    end
  end

  assign result_valid_o  = strobe_q;
  assign status_o        = status_q;
  assign fire_event_o    = fire_q;
  assign pending_count_o = count_q;
  assign next_time_o     = valid_w[0] ? time_w[0] : '0;

endmodule

>>> hw/rtl/setq_cell.sv
// One queue slot: holds a timestamp, compares against an insert and shifts to a neighbour.
module setq_cell
  import setq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  setq_ctrl_t       ctrl_i,
  input  logic             left_valid_i,
  input  logic             left_ge_i,
  input  logic [TimeW-1:0] left_time_i,
  input  logic             right_valid_i,
  input  logic [TimeW-1:0] right_time_i,
  output logic             valid_o,
  output logic             ge_o,
  output logic [TimeW-1:0] time_o
);

  logic             valid_q, valid_d;
  logic [TimeW-1:0] time_q, time_d;

  assign ge_o    = valid_q && (time_q >= ctrl_i.req_time);
  assign valid_o = valid_q;
  assign time_o  = time_q;

  always_comb begin
    valid_d = valid_q;
    time_d  = time_q;
    if (ctrl_i.clr) begin
      valid_d = 1'b0;
    end else if (ctrl_i.ins) begin
      valid_d = valid_q | left_valid_i;
      if (left_ge_i) begin
        time_d = left_time_i;
      end else if (ge_o || !valid_q) begin
        time_d = ctrl_i.req_time;
      end
    end else if (ctrl_i.pop) begin
      valid_d = right_valid_i;
      time_d  = right_time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
  end

endmodule

>>> sim/sorted_event_time_queue_top_test.sv
// Self-checking testbench for the sorted event time queue: directed and random command streams.
`timescale 1ns / 100ps

module sorted_event_time_queue_top_test
  import setq_pkg::*;
;

  typedef struct packed {
    setq_status_e      status;
    logic              fire;
    logic [4:0]        count;
    logic [TimeW-1:0]  head;
  } queue_result_t;

  class queue_scoreboard;
    logic [TimeW-1:0] win_lo;
    logic [TimeW-1:0] win_hi;
    logic [TimeW-1:0] slots[$];
    queue_result_t    awaited_results[$];
    int unsigned      errors;

    function new();
      win_lo = '0;
      win_hi = '1;
      errors = 0;
    endfunction

    function bit in_window(logic [TimeW-1:0] t);
      return t >= win_lo && t <= win_hi;
    endfunction

    function void note_write(setq_reg_e idx, logic [TimeW-1:0] data);
      if (idx == REG_MIN_VALID_TIME) win_lo = data;
      else win_hi = data;
    endfunction

    function queue_result_t predict_outcome(setq_op_e op, logic [TimeW-1:0] req,
                                            logic [TimeW-1:0] now, bit set, bit ok, bit pb);
      queue_result_t r;
      int unsigned   pos;
      r.status = ST_OK;
      r.fire   = 1'b0;
      case (op)
        OP_SCHEDULE: begin
          if (!set) r.status = ST_UNSET;
          else if (!in_window(req)) r.status = ST_WINDOW;
          else if (!ok) r.status = ST_READ_ERR;
          else if (req < now) r.status = ST_PAST;
          else if (slots.size() >= QueueDepth) r.status = ST_FULL;
          else begin
            // equal times go ahead of those already queued
            pos = 0;
            while (pos < slots.size() && slots[pos] < req) pos++;
            slots.insert(pos, req);
          end
        end
        OP_CHECK: begin
          if (!set) r.status = ST_UNSET;
          else if (!ok) begin
            slots.delete();
            r.status = ST_READ_ERR;
          end else if (!in_window(now)) begin
            slots.delete();
            r.status = ST_WINDOW;
          end else if (slots.size() > 0 && now >= slots[0]) begin
            void'(slots.pop_front());
            if (pb) r.status = ST_BUSY;
            else r.fire = 1'b1;
          end
        end
        OP_CLEAR: slots.delete();
        default: ;
      endcase
      r.count = 5'(slots.size());
      r.head  = slots.size() > 0 ? slots[0] : '0;
      return r;
    endfunction

    function void note_command(setq_op_e op, logic [TimeW-1:0] req, logic [TimeW-1:0] now,
                               bit set, bit ok, bit pb);
      awaited_results.push_back(predict_outcome(op, req, now, set, ok, pb));
    endfunction

    function void check_result(setq_status_e st, logic fire, logic [4:0] cnt,
                               logic [TimeW-1:0] head);
      queue_result_t e;
      if (awaited_results.size() == 0) begin
        $error("result with nothing outstanding: status %0d", st);
        errors++;
        return;
      end
      e = awaited_results.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (fire !== e.fire) begin
        $error("fire_event: expected %0d, got %0d", e.fire, fire);
        errors++;
      end
      if (cnt !== e.count) begin
        $error("pending_count: expected %0d, got %0d", e.count, cnt);
        errors++;
      end
      if (head !== e.head) begin
        $error("next_time: expected %0h, got %0h", e.head, head);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return awaited_results.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           operation_i = '0;
  logic [TimeW-1:0]     request_time_i = '0;
  logic [TimeW-1:0]     now_time_i = '0;
  logic                 clock_set_i = 1'b0;
  logic                 clock_read_ok_i = 1'b0;
  logic                 payload_busy_i = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [TimeW-1:0]     cfg_data_i = '0;
  logic                 result_valid_o;
  logic [2:0]           status_o;
  logic                 fire_event_o;
  logic [4:0]           pending_count_o;
  logic [TimeW-1:0]     next_time_o;

  queue_scoreboard queue_sb = new();

  logic [TimeW-1:0] win_lo = '0;
  logic [TimeW-1:0] win_hi = '1;
  logic [TimeW-1:0] cur_now = '0;
  int unsigned      sched_pct = 60;
  bit               gaps_on = 1'b1;

  sorted_event_time_queue_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .request_time_i (request_time_i),
    .now_time_i     (now_time_i),
    .clock_set_i    (clock_set_i),
    .clock_read_ok_i(clock_read_ok_i),
    .payload_busy_i (payload_busy_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .fire_event_o   (fire_event_o),
    .pending_count_o(pending_count_o),
    .next_time_o    (next_time_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o)
        queue_sb.check_result(setq_status_e'(status_o), fire_event_o, pending_count_o,
                              next_time_o);
      if (start && !busy)
        queue_sb.note_command(setq_op_e'(operation_i), request_time_i, now_time_i,
                              clock_set_i, clock_read_ok_i, payload_busy_i);
      if (cfg_valid_i && cfg_ready_o)
        queue_sb.note_write(setq_reg_e'(cfg_index_i), cfg_data_i);
    end
  end

  function automatic logic [TimeW-1:0] step_up(logic [TimeW-1:0] base, int unsigned d);
    logic [63:0] sum;
    sum = {32'd0, base} + 64'(d);
    if (win_lo <= win_hi && sum > {32'd0, win_hi}) sum = {32'd0, win_hi};
    if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
    return sum[31:0];
  endfunction

  task automatic issue(setq_op_e op, logic [TimeW-1:0] req, logic [TimeW-1:0] now,
                       bit set, bit ok, bit pb);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    operation_i     <= op;
    request_time_i  <= req;
    now_time_i      <= now;
    clock_set_i     <= set;
    clock_read_ok_i <= ok;
    payload_busy_i  <= pb;
    do @(posedge clk_i); while (busy);
  endtask

  // wait for every outstanding result, then leave a margin of idle clocks
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (queue_sb.outstanding() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_window(logic [TimeW-1:0] lo, logic [TimeW-1:0] hi);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_MIN_VALID_TIME;
    cfg_data_i  <= lo;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= REG_MAX_VALID_TIME;
    cfg_data_i  <= hi;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    win_lo = lo;
    win_hi = hi;
    cur_now = lo;
  endtask

  task automatic directed_items();
    issue(OP_SCHEDULE, 32'd500, 32'd200, 1'b0, 1'b1, 1'b0);
    issue(OP_SCHEDULE, 32'd0, 32'd200, 1'b1, 1'b1, 1'b0);
    issue(OP_SCHEDULE, 32'hFFFF_FFFF, 32'd200, 1'b1, 1'b1, 1'b0);
    issue(OP_SCHEDULE, 32'd500, 32'd200, 1'b1, 1'b0, 1'b0);
    issue(OP_SCHEDULE, 32'd500, 32'd600, 1'b1, 1'b1, 1'b0);
    issue(OP_CHECK, 32'd0, 32'd150, 1'b1, 1'b1, 1'b0);
    // fill with repeats and out-of-order times, top of window last
    for (int k = 0; k < 16; k++)
      issue(OP_SCHEDULE, k == 15 ? 32'hFFFF_FF00 : 32'(400 + ((k * 7) % 5) * 100),
            32'd400, 1'b1, 1'b1, 1'b0);
    issue(OP_SCHEDULE, 32'd600, 32'd400, 1'b1, 1'b1, 1'b0);
    issue(OP_CHECK, 32'd0, 32'd1000, 1'b0, 1'b1, 1'b0);
    issue(OP_CHECK, 32'd0, 32'd399, 1'b1, 1'b1, 1'b0);
    issue(OP_CHECK, 32'd0, 32'd400, 1'b1, 1'b1, 1'b1);
    issue(OP_CHECK, 32'd0, 32'd400, 1'b1, 1'b1, 1'b0);
    issue(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    issue(OP_CHECK, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
    issue(OP_SCHEDULE, 32'd700, 32'd400, 1'b1, 1'b1, 1'b0);
    issue(OP_CHECK, 32'd0, 32'd400, 1'b1, 1'b0, 1'b0);
    issue(OP_SCHEDULE, 32'd700, 32'd400, 1'b1, 1'b1, 1'b0);
    issue(OP_CLEAR, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0);
  endtask

  task automatic random_item();
    int unsigned      pick;
    setq_op_e         op;
    logic [TimeW-1:0] req;
    logic [TimeW-1:0] now;
    bit               set;
    bit               ok;
    bit               pb;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      op  = setq_op_e'($urandom_range(0, 3));
      req = $urandom;
      now = $urandom;
      set = 1'($urandom_range(0, 1));
      ok  = 1'($urandom_range(0, 1));
      pb  = 1'($urandom_range(0, 1));
    end else begin
      set  = $urandom_range(0, 24) != 0;
      ok   = $urandom_range(0, 39) != 0;
      pb   = $urandom_range(0, 3) == 0;
      req  = $urandom;
      now  = cur_now;
      pick = $urandom_range(0, 99);
      if (pick < sched_pct) begin
        op = OP_SCHEDULE;
        case ($urandom_range(0, 9))
          0: req = now - 32'($urandom_range(1, 50));
          1: ;
          default: req = step_up(now, $urandom_range(0, 400));
        endcase
      end else if (pick < 97) begin
        op = OP_CHECK;
        if ($urandom_range(0, 29) == 0) now = $urandom;
        else begin
          cur_now = step_up(cur_now, $urandom_range(0, 80));
          now = cur_now;
        end
      end else if (pick < 99) op = OP_CLEAR;
      else op = OP_UNUSED;
    end
    issue(op, req, now, set, ok, pb);
  endtask

  initial begin
    logic [TimeW-1:0] lo_tab[7];
    logic [TimeW-1:0] hi_tab[7];
    int unsigned      cnt_tab[7];
    logic [TimeW-1:0] base;
    base = $urandom_range(0, 32'hF000_0000);
    lo_tab = '{32'd0, 32'd1000, 32'd0, 32'hFFFF_FFFF, 32'd9000, base, 32'd0};
    hi_tab = '{32'hFFFF_FFFF, 32'd200000, 32'd0, 32'hFFFF_FFFF, 32'd8999,
               base + 32'd5000, 32'hFFFF_FFFF};
    cnt_tab = '{200, 150, 60, 60, 60, 150, 220};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_window(32'd100, 32'hFFFF_FF00);
    directed_items();
    settle();

    for (int p = 0; p < 7; p++) begin
      set_window(lo_tab[p], hi_tab[p]);
      if (p == 0) cur_now = $urandom_range(0, 32'hF000_0000);
      sched_pct = $urandom_range(45, 80);
      gaps_on = p != 6;
      for (int i = 0; i < cnt_tab[p]; i++) begin
        if (p != 6 && i % 50 == 0) gaps_on = $urandom_range(0, 3) != 0;
        if ($urandom_range(0, 149) == 0) settle();
        random_item();
      end
      settle();
    end

    if (queue_sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
